@@ sv/bresenham_line_rasterizer_unit_macros.svh @@
// assertion macros shared by the rasteriser rtl
`ifndef BRESENHAM_LINE_RASTERIZER_UNIT_MACROS_SVH
`define BRESENHAM_LINE_RASTERIZER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// checked only out of reset
`define BLR_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
// checked on every edge, reset included
`define BLR_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("assertion failed");
`else
`define BLR_ASSERT(lbl, clk, rst_n, prop)
`define BLR_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

@@ sv/blr_pkg.sv @@
package blr_pkg;

    localparam int TILE_SIZE = 64;
    localparam int COORD_W   = 6;
    localparam int ADDR_W    = 12;
    localparam int COLOR_W   = 24;
    // error term lies within about +-2*63
    localparam int ERR_W     = 9;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIFF,
        S_INIT,
        S_DRAW
    } t_state;

    typedef enum logic [1:0] {
        ERR_HOLD,
        ERR_INIT,
        ERR_STEP
    } t_err_op;

    typedef struct packed {
        t_err_op              op;
        logic [COORD_W-1:0]   major;
        logic [COORD_W-1:0]   minor;
    } t_err_ctrl;

endpackage

@@ sv/blr_if.sv @@
interface blr_line_if import blr_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] start_x;
    logic [COORD_W-1:0] start_y;
    logic [COORD_W-1:0] end_x;
    logic [COORD_W-1:0] end_y;
    logic [COLOR_W-1:0] line_color;

    modport source (output valid, start_x, start_y, end_x, end_y, line_color,
                    input ready);
    modport sink   (input valid, start_x, start_y, end_x, end_y, line_color,
                    output ready);
endinterface

interface blr_pix_if import blr_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
    logic [ADDR_W-1:0]  pixel_address;
    logic [COLOR_W-1:0] pixel_color;
    logic               last_pixel;

    modport source (output valid, pixel_x, pixel_y, pixel_address, pixel_color,
                    last_pixel, input ready);
    modport sink   (input valid, pixel_x, pixel_y, pixel_address, pixel_color,
                    last_pixel, output ready);
endinterface

@@ sv/blr_err_unit.sv @@
module blr_err_unit import blr_pkg::*; (
    input  logic      i_clk,
    input  t_err_ctrl i_ctrl,
    output logic      o_err_pos
);

    logic signed [ERR_W-1:0] r_err;
    logic signed [ERR_W-1:0] n_err;
    logic signed [ERR_W-1:0] w_two_minor;
    logic signed [ERR_W-1:0] w_two_major;
    logic signed [ERR_W-1:0] w_opa;
    logic signed [ERR_W-1:0] w_opb;

    assign w_two_minor = $signed({2'b00, i_ctrl.minor, 1'b0});
    assign w_two_major = $signed({2'b00, i_ctrl.major, 1'b0});
    assign o_err_pos   = (r_err > 0);

    // the one adder, fed by the sequencer's operation
    always_comb begin
        w_opa = r_err;
        w_opb = '0;
        unique case (i_ctrl.op)
            ERR_INIT: begin
                w_opa = w_two_minor;
                w_opb = -$signed({3'b000, i_ctrl.major});
            end
            ERR_STEP: begin
                w_opa = r_err;
                w_opb = o_err_pos ? (w_two_minor - w_two_major) : w_two_minor;
            end
            default: begin
                w_opa = r_err;
                w_opb = '0;
            end
        endcase
        n_err = w_opa + w_opb;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.op != ERR_HOLD) begin
            r_err <= n_err;
        end
    end

endmodule

@@ sv/bresenham_line_rasterizer_unit.sv @@
// channel  | dir | handshake     | beat
// i_line   | in  | valid / ready | start_x, start_y, end_x, end_y, line_color
// o_pix    | out | valid / ready | pixel_x, pixel_y, pixel_address, pixel_color,
//          |     |               | last_pixel
//
// a line of major length m is handled in order: accept, the axis
// differences, the error seed on the shared adder, then m + 1 pixels
// i_line.ready is high only while idle; the last pixel may still sit in the
// output register when the next line is accepted
// a stall on o_pix freezes the walk with the pending pixel held
// i_rst_n is synchronous, active low, and clears sequencer and output valid
`include "bresenham_line_rasterizer_unit_macros.svh"

module bresenham_line_rasterizer_unit import blr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    blr_line_if.sink    i_line,
    blr_pix_if.source   o_pix
);

    t_state             r_state, n_state;
    logic [COORD_W-1:0] r_x, n_x;
    logic [COORD_W-1:0] r_y, n_y;
    logic [COORD_W-1:0] r_x1, n_x1;
    logic [COORD_W-1:0] r_y1, n_y1;
    logic [COLOR_W-1:0] r_color, n_color;
    logic [COORD_W-1:0] r_major, n_major;
    logic [COORD_W-1:0] r_minor, n_minor;
    logic               r_sx_neg, n_sx_neg;
    logic               r_sy_neg, n_sy_neg;
    logic               r_xmaj, n_xmaj;
    logic [COORD_W-1:0] r_cnt, n_cnt;

    logic               r_ov, n_ov;
    logic [COORD_W-1:0] r_px, n_px;
    logic [COORD_W-1:0] r_py, n_py;
    logic [ADDR_W-1:0]  r_paddr, n_paddr;
    logic [COLOR_W-1:0] r_pcolor, n_pcolor;
    logic               r_plast, n_plast;

    logic               w_accept;
    logic               w_out_free;
    logic               w_err_pos;
    logic [COORD_W-1:0] w_dx, w_dy;
    logic [COORD_W-1:0] w_step_x, w_step_y;
    t_err_ctrl          w_err_ctrl;

    assign i_line.ready    = (r_state == S_IDLE);
    assign w_accept        = i_line.valid && i_line.ready;
    assign w_out_free      = !r_ov || o_pix.ready;

    assign o_pix.valid         = r_ov;
    assign o_pix.pixel_x       = r_px;
    assign o_pix.pixel_y       = r_py;
    assign o_pix.pixel_address = r_paddr;
    assign o_pix.pixel_color   = r_pcolor;
    assign o_pix.last_pixel    = r_plast;

    assign w_dx     = (r_x1 >= r_x) ? (r_x1 - r_x) : (r_x - r_x1);
    assign w_dy     = (r_y1 >= r_y) ? (r_y1 - r_y) : (r_y - r_y1);
    assign w_step_x = r_sx_neg ? (r_x - COORD_W'(1)) : (r_x + COORD_W'(1));
    assign w_step_y = r_sy_neg ? (r_y - COORD_W'(1)) : (r_y + COORD_W'(1));

    blr_err_unit u_err (
        .i_clk     (i_clk),
        .i_ctrl    (w_err_ctrl),
        .o_err_pos (w_err_pos)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x      <= n_x;
        r_y      <= n_y;
        r_x1     <= n_x1;
        r_y1     <= n_y1;
        r_color  <= n_color;
        r_major  <= n_major;
        r_minor  <= n_minor;
        r_sx_neg <= n_sx_neg;
        r_sy_neg <= n_sy_neg;
        r_xmaj   <= n_xmaj;
        r_cnt    <= n_cnt;
        r_px     <= n_px;
        r_py     <= n_py;
        r_paddr  <= n_paddr;
        r_pcolor <= n_pcolor;
        r_plast  <= n_plast;
    end

    always_comb begin
        n_state  = r_state;
        n_x      = r_x;
        n_y      = r_y;
        n_x1     = r_x1;
        n_y1     = r_y1;
        n_color  = r_color;
        n_major  = r_major;
        n_minor  = r_minor;
        n_sx_neg = r_sx_neg;
        n_sy_neg = r_sy_neg;
        n_xmaj   = r_xmaj;
        n_cnt    = r_cnt;
        n_ov     = r_ov && !o_pix.ready;
        n_px     = r_px;
        n_py     = r_py;
        n_paddr  = r_paddr;
        n_pcolor = r_pcolor;
        n_plast  = r_plast;
        w_err_ctrl.op    = ERR_HOLD;
        w_err_ctrl.major = r_major;
        w_err_ctrl.minor = r_minor;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_x     = i_line.start_x;
                    n_y     = i_line.start_y;
                    n_x1    = i_line.end_x;
                    n_y1    = i_line.end_y;
                    n_color = i_line.line_color;
                    n_state = S_DIFF;
                end
            end
            S_DIFF: begin
                n_sx_neg = (r_x1 < r_x);
                n_sy_neg = (r_y1 < r_y);
                // ties go to y as the major axis
                n_xmaj   = (w_dx > w_dy);
                n_major  = (w_dx > w_dy) ? w_dx : w_dy;
                n_minor  = (w_dx > w_dy) ? w_dy : w_dx;
                n_state  = S_INIT;
            end
            S_INIT: begin
                w_err_ctrl.op = ERR_INIT;
                n_cnt   = r_major;
                n_state = S_DRAW;
            end
            S_DRAW: begin
                if (w_out_free) begin
                    n_ov     = 1'b1;
                    n_px     = r_x;
                    n_py     = r_y;
                    n_paddr  = ADDR_W'(ADDR_W'(r_y) * ADDR_W'(TILE_SIZE)) + ADDR_W'(r_x);
                    n_pcolor = r_color;
                    n_plast  = (r_cnt == '0);
                    if (r_cnt == '0) begin
                        n_state = S_IDLE;
                    end else begin
                        w_err_ctrl.op = ERR_STEP;
                        n_cnt = r_cnt - COORD_W'(1);
                        // major axis always steps, minor when the error is positive
                        if (r_xmaj) begin
                            n_x = w_step_x;
                            if (w_err_pos) begin
                                n_y = w_step_y;
                            end
                        end else begin
                            n_y = w_step_y;
                            if (w_err_pos) begin
                                n_x = w_step_x;
                            end
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    `BLR_ASSERT(a_accept_leaves_idle, i_clk, i_rst_n,
        w_accept |=> (r_state == S_DIFF) && !i_line.ready)
    `BLR_ASSERT(a_walk_ends_at_end, i_clk, i_rst_n,
        (r_state == S_DRAW) && (r_cnt == '0) |-> (r_x == r_x1) && (r_y == r_y1))
    `BLR_ASSERT(a_last_returns_idle, i_clk, i_rst_n,
        (r_state == S_DRAW) && w_out_free && (r_cnt == '0)
            |=> r_ov && r_plast && (r_state == S_IDLE))
    `BLR_ASSERT_ALWAYS(a_reset_clears, i_clk, !i_rst_n |=> !r_ov && (r_state == S_IDLE))

endmodule
